### design/mbpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpb_pkg: shared types and constants of the monochrome bitmap blitter
// Register indexes, orientation codes and the byte descriptor that travels
// from the front end through the queue to the pixel back end.
// ----------------------------------------------------------------------------
package mbpb_pkg;

    localparam int COORD_BITS     = 8;
    localparam int BYTE_BITS      = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 8;
    localparam int QUEUE_DEPTH    = 2;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_BITMAP_WIDTH  = 3'd2,
        REG_BITMAP_HEIGHT = 3'd3,
        REG_ORIENTATION   = 3'd4,
        REG_INK_COLOR     = 3'd5,
        REG_TRANSPARENT   = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ORIENT_NORMAL    = 2'd0,
        ORIENT_ROTATED   = 2'd1,
        ORIENT_VFLIP     = 2'd2,
        ORIENT_TRANSPOSE = 2'd3
    } orient_t;

    // Everything the back end needs to turn one source byte into pixel writes.
    typedef struct packed {
        logic [BYTE_BITS-1:0] mask;      // bits that produce a pixel write
        logic [BYTE_BITS-1:0] bits;      // raw source byte, selects the colour
        logic                 ink;
        logic                 col_in_y;  // source column runs along y
        coord_t               fixed;     // coordinate set by the source row
        coord_t               col_base;  // coordinate of bit 0 of this byte
        logic                 done;      // byte ends the bitmap
    } desc_t;

endpackage

### design/mbpb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpb_front: register file and byte classifier
// Holds the configuration registers and the row/byte counters, and turns each
// accepted source byte into a descriptor for the pixel back end.
// ----------------------------------------------------------------------------
module mbpb_front
    import mbpb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [BYTE_BITS-1:0]      s_bitmap_byte,
    input  logic                      q_full,
    output logic                      q_push,
    output desc_t                     q_data
);

    logic [7:0] origin_x_reg;
    logic [7:0] origin_y_reg;
    logic [7:0] width_reg;
    logic [7:0] height_reg;
    orient_t    orient_reg;
    logic       ink_reg;
    logic       transparent_reg;

    logic [7:0] row_count_reg, row_count_next;
    logic [4:0] byte_in_row_reg, byte_in_row_next;

    logic       accept;
    logic [8:0] width_sum;
    logic [5:0] blen;
    logic       row_end;
    logic       last_row;
    logic [7:0] rev;
    logic [7:0] col_base;
    logic [8:0] col;
    logic [BYTE_BITS-1:0] mask;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= 8'd0;
            origin_y_reg    <= 8'd0;
            width_reg       <= 8'd8;
            height_reg      <= 8'd8;
            orient_reg      <= ORIENT_NORMAL;
            ink_reg         <= 1'b1;
            transparent_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:      origin_x_reg    <= cfg_data[7:0];
                REG_ORIGIN_Y:      origin_y_reg    <= cfg_data[7:0];
                REG_BITMAP_WIDTH:  width_reg       <= cfg_data[7:0];
                REG_BITMAP_HEIGHT: height_reg      <= cfg_data[7:0];
                REG_ORIENTATION:   orient_reg      <= orient_t'(cfg_data[1:0]);
                REG_INK_COLOR:     ink_reg         <= cfg_data[0];
                REG_TRANSPARENT:   transparent_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        width_sum = {1'b0, width_reg} + 9'd7;
        blen      = width_sum[8:3];
        if (blen == 6'd0) begin
            blen = 6'd1;
        end
        row_end  = ({1'b0, byte_in_row_reg} + 6'd1) >= blen;
        last_row = ({1'b0, row_count_reg} + 9'd1) >= {1'b0, height_reg};
        rev      = height_reg - 8'd1 - row_count_reg;
        col_base = {byte_in_row_reg, 3'b000};

        // A bit writes a pixel when it lies inside the row and is either set
        // or painted in the inverse colour.
        for (int i = 0; i < BYTE_BITS; i++) begin
            col     = {1'b0, col_base} + 9'(i);
            mask[i] = (col < {1'b0, width_reg})
                      && (s_bitmap_byte[i] || !transparent_reg);
        end

        q_data.mask = mask;
        q_data.bits = s_bitmap_byte;
        q_data.ink  = ink_reg;
        q_data.done = row_end && last_row;
        case (orient_reg)
            ORIENT_NORMAL: begin
                q_data.col_in_y = 1'b0;
                q_data.fixed    = origin_y_reg + row_count_reg;
                q_data.col_base = origin_x_reg + col_base;
            end
            ORIENT_ROTATED: begin
                q_data.col_in_y = 1'b1;
                q_data.fixed    = origin_x_reg + rev;
                q_data.col_base = origin_y_reg + col_base;
            end
            ORIENT_VFLIP: begin
                q_data.col_in_y = 1'b0;
                q_data.fixed    = origin_y_reg + rev;
                q_data.col_base = origin_x_reg + col_base;
            end
            default: begin
                q_data.col_in_y = 1'b1;
                q_data.fixed    = origin_x_reg + row_count_reg;
                q_data.col_base = origin_y_reg + col_base;
            end
        endcase

        // Bytes without a single pixel write still move the counters.
        q_push = accept && (mask != '0);

        row_count_next   = row_count_reg;
        byte_in_row_next = byte_in_row_reg;
        if (accept) begin
            if (row_end) begin
                byte_in_row_next = 5'd0;
                row_count_next   = last_row ? 8'd0 : row_count_reg + 8'd1;
            end else begin
                byte_in_row_next = byte_in_row_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg   <= 8'd0;
            byte_in_row_reg <= 5'd0;
        end else begin
            row_count_reg   <= row_count_next;
            byte_in_row_reg <= byte_in_row_next;
        end
    end

endmodule

### design/mbpb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpb_queue: descriptor queue
// A short first-in first-out buffer that lets the front end run ahead of the
// pixel back end.
// ----------------------------------------------------------------------------
module mbpb_queue
    import mbpb_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output desc_t head
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    desc_t               store [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/mbpb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpb_back: pixel write sequencer
// Walks the write mask of the current descriptor, one pixel per cycle while the
// result channel accepts, into a registered result stage.
// ----------------------------------------------------------------------------
module mbpb_back
    import mbpb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  desc_t      q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_pixel_x,
    output logic [7:0] m_pixel_y,
    output logic       m_pixel_color,
    output logic       m_last_of_byte,
    output logic       m_bitmap_done
);

    desc_t                cur_reg, cur_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           x_reg, y_reg;
    logic                 color_reg, last_reg, done_reg;

    logic [2:0]           idx;
    logic [BYTE_BITS-1:0] mask_left;
    logic                 advance;
    logic                 last;
    coord_t               var_coord;

    always_comb begin
        idx = 3'd0;
        for (int i = BYTE_BITS - 1; i >= 0; i--) begin
            if (cur_reg.mask[i]) begin
                idx = 3'(i);
            end
        end
        mask_left = cur_reg.mask & ~(BYTE_BITS'(1) << idx);
        last      = (mask_left == '0);
        advance   = cur_valid_reg && (!m_valid_reg || m_ready);
        q_pop     = q_not_empty && (!cur_valid_reg || (advance && last));
        var_coord = cur_reg.col_base + coord_t'(idx);

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (q_pop) begin
            cur_next       = q_head;
            cur_valid_next = 1'b1;
        end else if (advance) begin
            cur_next.mask  = mask_left;
            cur_valid_next = !last;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (advance) begin
            x_reg     <= cur_reg.col_in_y ? cur_reg.fixed[7:0] : var_coord[7:0];
            y_reg     <= cur_reg.col_in_y ? var_coord[7:0] : cur_reg.fixed[7:0];
            color_reg <= cur_reg.bits[idx] ? cur_reg.ink : !cur_reg.ink;
            last_reg  <= last;
            done_reg  <= cur_reg.done;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = x_reg;
    assign m_pixel_y      = y_reg;
    assign m_pixel_color  = color_reg;
    assign m_last_of_byte = last_reg;
    assign m_bitmap_done  = done_reg;

endmodule

### design/mono_bitmap_pixel_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bitmap_pixel_blitter: one-bit-per-pixel bitmap blitter
// Turns a stream of bitmap bytes, least significant bit leftmost, into pixel
// writes with screen coordinates and colour, in one of four orientations.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_bitmap_byte (8)
// m_        out        m_valid / m_ready    m_pixel_x (8), m_pixel_y (8),
//                                           m_pixel_color, m_last_of_byte,
//                                           m_bitmap_done
// cfg_      in         cfg_valid/cfg_ready  cfg_index (3), cfg_data (8)
//
// The back end issues one pixel write per cycle while the result channel
// accepts. Bytes with no writes never enter the descriptor queue. The first
// write of a byte passes through its queue entry, the current descriptor
// register and the result stage.
// Reset is synchronous and active low; it restores the register defaults and
// empties the queue. A stalled result channel fills the two-entry descriptor
// queue, after which s_ready drops until the back end drains an entry.
module mono_bitmap_pixel_blitter
    import mbpb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_bitmap_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_pixel_x,
    output logic [7:0]                m_pixel_y,
    output logic                      m_pixel_color,
    output logic                      m_last_of_byte,
    output logic                      m_bitmap_done
);

    // Descriptor path from the classifier to the pixel sequencer.
    logic  q_push;
    desc_t q_push_data;
    logic  q_full;
    logic  q_pop;
    logic  q_not_empty;
    desc_t q_head;

    // The front end owns the registers and the row/byte counters. Each byte is
    // classified in the cycle of its transfer, using the registers as they
    // stand, and only bytes that produce at least one write are queued.
    mbpb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_bitmap_byte (s_bitmap_byte),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    // The queue decouples the input side from the stalls of the result side.
    mbpb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // The back end loads the next descriptor in the same cycle that the last
    // write of the current one issues, so consecutive bytes leave without a
    // gap.
    mbpb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_color  (m_pixel_color),
        .m_last_of_byte (m_last_of_byte),
        .m_bitmap_done  (m_bitmap_done)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mono_bitmap_pixel_blitter
// Streams bitmap bytes under many register settings and checks every pixel
// write, in order and field by field, against a predictor that keeps its own
// copy of the registers and of the row and byte counters.
// ----------------------------------------------------------------------------
module testbench;
    import mbpb_pkg::*;

    // One predicted or observed pixel write.
    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
        logic       last;
        logic       done;
    } pixel_write_t;

    // Cycles allowed after the last expected write before the block counts as
    // idle. A byte without writes still moves the row and byte counters, though
    // it never enters the descriptor queue.
    localparam int DRAIN_CYCLES = 16;

    logic                      aclk;
    logic                      aresetn       = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    cfg_reg_t                  cfg_index     = REG_ORIGIN_X;
    logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic [7:0]                s_bitmap_byte = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic [7:0]                m_pixel_x;
    logic [7:0]                m_pixel_y;
    logic                      m_pixel_color;
    logic                      m_last_of_byte;
    logic                      m_bitmap_done;

    mono_bitmap_pixel_blitter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_bitmap_byte  (s_bitmap_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_color  (m_pixel_color),
        .m_last_of_byte (m_last_of_byte),
        .m_bitmap_done  (m_bitmap_done)
    );

    // Bytes waiting to be offered on the input channel, and pixel writes that
    // the predictor expects but the result channel has not delivered yet.
    logic [7:0]   byte_feed[$];
    pixel_write_t pending_pixels[$];

    // Percentage of cycles in which the sender holds back and the receiver
    // refuses a transfer.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Set when the input transfer of the previous rising edge took place.
    logic byte_taken = 1'b0;
    int   mismatches = 0;

    // Shadow registers, starting at their reset values.
    logic [7:0] sh_origin_x    = 8'd0;
    logic [7:0] sh_origin_y    = 8'd0;
    logic [7:0] sh_width       = 8'd8;
    logic [7:0] sh_height      = 8'd8;
    orient_t    sh_orient      = ORIENT_NORMAL;
    logic       sh_ink         = 1'b1;
    logic       sh_transparent = 1'b0;

    // Position of the next source byte within the bitmap.
    logic [7:0] row_cnt  = 8'd0;
    logic [4:0] byte_col = 5'd0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Works out the pixel writes caused by one source byte and advances the
    // row and byte counters, exactly as the block must.
    task automatic predict_pixels(input logic [7:0] src);
        int           row_bytes;
        int           col;
        int           first_idx;
        bit           row_end;
        bit           last_row;
        bit           done;
        logic [7:0]   rev_row;
        logic [7:0]   col8;
        pixel_write_t pw;
        first_idx = pending_pixels.size();
        // A zero width still makes a row one byte long.
        row_bytes = (int'(sh_width) + 7) >> 3;
        if (row_bytes == 0) begin
            row_bytes = 1;
        end
        // Counters standing past the end, after a register change, end the
        // row or the bitmap. A zero height makes every row the final one.
        row_end  = int'(byte_col) + 1 >= row_bytes;
        last_row = int'(row_cnt) + 1 >= int'(sh_height);
        done     = row_end && last_row;
        rev_row  = sh_height - 8'd1 - row_cnt;
        for (int i = 0; i < 8; i++) begin
            col = int'(byte_col) * 8 + i;
            // Padding bits past the row width emit nothing.
            if (col >= int'(sh_width)) begin
                break;
            end
            if (!src[i] && sh_transparent) begin
                continue;
            end
            col8 = col[7:0];
            case (sh_orient)
                ORIENT_NORMAL: begin
                    pw.x = sh_origin_x + col8;
                    pw.y = sh_origin_y + row_cnt;
                end
                ORIENT_ROTATED: begin
                    pw.x = sh_origin_x + rev_row;
                    pw.y = sh_origin_y + col8;
                end
                ORIENT_VFLIP: begin
                    pw.x = sh_origin_x + col8;
                    pw.y = sh_origin_y + rev_row;
                end
                default: begin
                    pw.x = sh_origin_x + row_cnt;
                    pw.y = sh_origin_y + col8;
                end
            endcase
            pw.color = src[i] ? sh_ink : ~sh_ink;
            pw.last  = 1'b0;
            pw.done  = done;
            pending_pixels.push_back(pw);
        end
        if (pending_pixels.size() > first_idx) begin
            pending_pixels[pending_pixels.size() - 1].last = 1'b1;
        end
        if (row_end) begin
            byte_col = 5'd0;
            row_cnt  = last_row ? 8'd0 : row_cnt + 8'd1;
        end else begin
            byte_col = byte_col + 5'd1;
        end
    endtask

    // Compares one pixel write from the result channel with the oldest
    // expectation.
    task automatic check_pixel_write();
        pixel_write_t got;
        pixel_write_t want;
        got = '{x: m_pixel_x, y: m_pixel_y, color: m_pixel_color,
                last: m_last_of_byte, done: m_bitmap_done};
        if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: unexpected pixel write x=%0d y=%0d color=%0b last=%0b done=%0b",
                         $realtime, got.x, got.y, got.color, got.last, got.done);
            end
        end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: pixel write mismatch", $realtime);
                    $display("    expected x=%0d y=%0d color=%0b last=%0b done=%0b",
                             want.x, want.y, want.color, want.last, want.done);
                    $display("    actual   x=%0d y=%0d color=%0b last=%0b done=%0b",
                             got.x, got.y, got.color, got.last, got.done);
                end
            end
        end
    endtask

    // Monitor: everything is sampled at the rising edge. A register write
    // updates the shadow copy, a result transfer is checked, and an input
    // transfer feeds the predictor. An input byte cannot produce a write in
    // the same cycle, so the order of the last two does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ORIGIN_X:      sh_origin_x    = cfg_data;
                    REG_ORIGIN_Y:      sh_origin_y    = cfg_data;
                    REG_BITMAP_WIDTH:  sh_width       = cfg_data;
                    REG_BITMAP_HEIGHT: sh_height      = cfg_data;
                    REG_ORIENTATION:   sh_orient      = orient_t'(cfg_data[1:0]);
                    REG_INK_COLOR:     sh_ink         = cfg_data[0];
                    REG_TRANSPARENT:   sh_transparent = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                check_pixel_write();
            end
            if (s_valid && s_ready) begin
                predict_pixels(s_bitmap_byte);
            end
        end
        byte_taken <= aresetn && s_valid && s_ready;
    end

    // Driver: inputs change at the falling edge. A new byte is offered only
    // once the previous one has been transferred, and valid stays high with
    // the same byte until then. The receiver's ready is redrawn every cycle.
    always @(negedge aclk) begin
        if (!s_valid || byte_taken) begin
            if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_bitmap_byte <= byte_feed.pop_front();
                s_valid       <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end

    // Writes one register through the configuration channel and returns at
    // a rising edge, after the monitor has seen the transfer.
    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [7:0] ox, input logic [7:0] oy,
                               input logic [7:0] w, input logic [7:0] h,
                               input orient_t orient, input logic ink,
                               input logic transp);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_BITMAP_WIDTH, w);
        write_reg(REG_BITMAP_HEIGHT, h);
        write_reg(REG_ORIENTATION, {6'd0, orient});
        write_reg(REG_INK_COLOR, {7'd0, ink});
        write_reg(REG_TRANSPARENT, {7'd0, transp});
    endtask

    // Waits until every byte is transferred and every expected write has
    // arrived, then lets the block finish bytes that cause no writes.
    task automatic wait_idle();
        do @(posedge aclk);
        while (byte_feed.size() != 0 || s_valid || pending_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random register value; sizes are mostly small so that whole bitmaps
    // fit into one phase, with the extremes now and then.
    function automatic logic [7:0] pick_value(input cfg_reg_t idx);
        case (idx)
            REG_ORIGIN_X, REG_ORIGIN_Y: begin
                return ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
            end
            REG_BITMAP_WIDTH: begin
                case ($urandom_range(0, 9))
                    0:       return 8'd0;
                    1:       return 8'd255;
                    2:       return 8'($urandom_range(0, 255));
                    default: return 8'($urandom_range(1, 24));
                endcase
            end
            REG_BITMAP_HEIGHT: begin
                case ($urandom_range(0, 9))
                    0:       return 8'd0;
                    1:       return 8'd255;
                    2:       return 8'($urandom_range(0, 255));
                    default: return 8'($urandom_range(1, 5));
                endcase
            end
            REG_ORIENTATION: return 8'($urandom_range(0, 3));
            default:         return 8'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int bitmap_len;
        int reps;
        int phase_bytes;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The directed part runs with the first idling pattern.
        send_idle_pct = 24;
        recv_idle_pct = 74;

        // Reset settings: one 8-pixel row per byte, a full 8-row bitmap with
        // the extreme byte values and alternating patterns.
        byte_feed = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'h3C, 8'hC3};
        wait_idle();

        // Rotated with wrapping coordinates, a padded second byte per row,
        // inverted ink and transparency, including an all-clear byte.
        load_config(8'd250, 8'd253, 8'd12, 8'd2, ORIENT_ROTATED, 1'b0, 1'b1);
        byte_feed = '{8'hFF, 8'hFF, 8'h00, 8'h0F};
        wait_idle();

        // Zero width emits nothing at all; then zero height, where every row
        // ends the bitmap, under a vertical flip at the far corner.
        load_config(8'd255, 8'd255, 8'd0, 8'd0, ORIENT_VFLIP, 1'b1, 1'b0);
        byte_feed = '{8'hFF, 8'h00};
        wait_idle();
        write_reg(REG_BITMAP_WIDTH, 8'd8);
        byte_feed = '{8'h5A, 8'hA5};
        wait_idle();

        // Largest bitmap, transposed, left in the middle of its first row.
        load_config(8'd0, 8'd0, 8'd255, 8'd255, ORIENT_TRANSPOSE, 1'b1, 1'b0);
        byte_feed = '{8'h81, 8'h7E, 8'hF0};
        wait_idle();

        // Shrinking the bitmap under the running counters: the next byte
        // lies past the new row end, writes nothing and closes the bitmap.
        write_reg(REG_BITMAP_WIDTH, 8'd1);
        write_reg(REG_BITMAP_HEIGHT, 8'd1);
        write_reg(REG_ORIENTATION, {6'd0, ORIENT_NORMAL});
        byte_feed = '{8'h01, 8'hFE};
        wait_idle();

        // Random phases: new register values, then mostly whole bitmaps with
        // random content. Some phases stop part way through a bitmap so that
        // the next settings meet counters in the middle of a row.
        for (int ph = 0; ph < 14; ph++) begin
            if (ph < 5) begin
                send_idle_pct = 24;
                recv_idle_pct = 74;
            end else if (ph < 10) begin
                send_idle_pct = 74;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int r = int'(REG_ORIGIN_X); r <= int'(REG_TRANSPARENT); r++) begin
                if ($urandom_range(0, 9) < 7) begin
                    write_reg(cfg_reg_t'(r), pick_value(cfg_reg_t'(r)));
                end
            end
            bitmap_len = (int'(sh_width) + 7) >> 3;
            if (bitmap_len == 0) begin
                bitmap_len = 1;
            end
            if (sh_height != 8'd0) begin
                bitmap_len = bitmap_len * int'(sh_height);
            end
            if (bitmap_len <= 40) begin
                reps        = (bitmap_len >= 24) ? 1 : 24 / bitmap_len;
                phase_bytes = reps * bitmap_len;
                if ($urandom_range(0, 4) == 0) begin
                    phase_bytes += $urandom_range(1, 3);
                end
            end else begin
                phase_bytes = $urandom_range(5, 30);
            end
            for (int b = 0; b < phase_bytes; b++) begin
                byte_feed.push_back(pick_byte());
            end
            wait_idle();
        end

        mismatches += pending_pixels.size();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
design/mbpb_pkg.sv
design/mbpb_front.sv
design/mbpb_queue.sv
design/mbpb_back.sv
design/mono_bitmap_pixel_blitter.sv
sim/testbench.sv
